// File: hdl/bfnn_pkg.sv
// ----------------------------------------------------------------------------
// bfnn_pkg
// Shared types and constants of the nearest-neighbor table.
// ----------------------------------------------------------------------------
package bfnn_pkg;

	localparam int OP_W    = 3;
	localparam int ID_W    = 16;
	localparam int IN_CW   = 16;
	localparam int MAX_DIM = 6;
	localparam int DIST_W  = 35;
	localparam int K_W     = 7;
	localparam int STS_W   = 2;

	localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
	localparam logic [OP_W-1:0] OP_FIND    = 3'd2;
	localparam logic [OP_W-1:0] OP_NEAREST = 3'd3;
	localparam logic [OP_W-1:0] OP_RADIUS  = 3'd4;
	localparam logic [OP_W-1:0] OP_KNN     = 3'd5;

	localparam logic [STS_W-1:0] STS_OK      = 2'd0;
	localparam logic [STS_W-1:0] STS_FULL    = 2'd1;
	localparam logic [STS_W-1:0] STS_NOMATCH = 2'd2;
	localparam logic [STS_W-1:0] STS_EMPTY   = 2'd3;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [ID_W-1:0]          id;
		logic [MAX_DIM*IN_CW-1:0] coords;
		logic [DIST_W-1:0]        radius;
		logic [K_W-1:0]           k;
	} cmd_t;

	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] dist_sq;
		logic              present;
		logic              last;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DRD,
		S_DLD,
		S_DMUL,
		S_SEL,
		S_FINAL,
		S_REPLY
	} bk_state_t;

endpackage

// File: hdl/bfnn_fifo.sv
// ----------------------------------------------------------------------------
// bfnn_fifo
// Small synchronous queue, used between front and back and on the results.
// ----------------------------------------------------------------------------
module bfnn_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             wr_ok, rd_ok;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_ok = wr & ~full;
	assign rd_ok = rd & ~empty;
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_ok)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd_ok)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (wr_ok && !rd_ok)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_ok && !wr_ok)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok)
			mem_q[wp_q] <= din;
	end

endmodule

// File: hdl/bfnn_front.sv
// ----------------------------------------------------------------------------
// bfnn_front
// Input stage: registers an item, drops undefined operations, queues commands.
// ----------------------------------------------------------------------------
module bfnn_front import bfnn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [OP_W-1:0]    operation,
	input  logic [ID_W-1:0]    point_id,
	input  logic signed [15:0] coord_0,
	input  logic signed [15:0] coord_1,
	input  logic signed [15:0] coord_2,
	input  logic signed [15:0] coord_3,
	input  logic signed [15:0] coord_4,
	input  logic signed [15:0] coord_5,
	input  logic [DIST_W-1:0]  radius_sq,
	input  logic [K_W-1:0]     count_k,
	input  logic               cmd_full,
	output logic               cmd_push,
	output cmd_t               cmd
);
	logic v_s1;
	cmd_t cmd_s1;
	logic op_ok;
	logic acc;

	assign full = v_s1 & cmd_full;
	assign acc  = push & ~full;

	always_comb begin
		case (cmd_s1.op) inside
			[OP_INSERT:OP_KNN]: op_ok = 1'b1;
			default:            op_ok = 1'b0;
		endcase
	end

	assign cmd_push = v_s1 & ~cmd_full & op_ok;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (acc)
			v_s1 <= 1'b1;
		else if (v_s1 && !cmd_full)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1.op     <= operation;
			cmd_s1.id     <= point_id;
			cmd_s1.coords <= {coord_5, coord_4, coord_3, coord_2, coord_1, coord_0};
			cmd_s1.radius <= radius_sq;
			cmd_s1.k      <= count_k;
		end
	end

endmodule

// File: hdl/bfnn_back.sv
// ----------------------------------------------------------------------------
// bfnn_back
// Execution engine: point store, distance pass and selection passes.
// ----------------------------------------------------------------------------
module bfnn_back import bfnn_pkg::*; #(
	parameter int CAPACITY    = 64,
	parameter int DIMENSIONS  = 6,
	parameter int COORD_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_empty,
	input  cmd_t cmd_data,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res_data
);
	localparam int AW   = $clog2(CAPACITY);
	localparam int CNTW = $clog2(CAPACITY + 1);
	localparam int SB   = (COORD_WIDTH < IN_CW) ? COORD_WIDTH : IN_CW;
	localparam int CRW  = DIMENSIONS * SB;
	localparam int DW   = $clog2(DIMENSIONS + 1);
	localparam int ACW  = DIST_W + 3;
	localparam logic [CNTW-1:0] CAP_N = CNTW'(CAPACITY);
	localparam logic [DW-1:0]   DIM_N = DW'(DIMENSIONS);

	function automatic logic [CRW-1:0] pack_crd(input logic [MAX_DIM*IN_CW-1:0] c);
		logic [CRW-1:0] r;
		r = '0;
		for (int d = 0; d < DIMENSIONS; d++)
			r[d*SB +: SB] = c[d*IN_CW +: SB];
		return r;
	endfunction

	// point store and scratch distances
	logic [ID_W-1:0]   ids_mem  [CAPACITY];
	logic [CRW-1:0]    crd_mem  [CAPACITY];
	logic [DIST_W-1:0] dist_mem [CAPACITY];
	logic [ID_W-1:0]   id_rd_q;
	logic [CRW-1:0]    crd_rd_q;
	logic [DIST_W-1:0] dist_rd_q;
	logic [AW-1:0]     rd_addr;

	bk_state_t state_q, state_d, ret_q;
	cmd_t             cmd_q;
	logic [CNTW-1:0]  cnt_q, iss_q;
	logic [AW-1:0]    idx_q, slot_s1;
	logic             v_s1;
	res_t             reply_q;

	// distance datapath
	logic [CRW-1:0]         crd_sh_q, qry_sh_q;
	logic [DW-1:0]          dim_q;
	logic signed [SB:0]     diff_s1;
	logic signed [2*SB+1:0] sq_s2;
	logic                   dv_s1, dv_s2;
	logic [ACW-1:0]         acc_q;
	logic [DIST_W-1:0]      dsat;

	// selection state
	logic [DIST_W-1:0] best_d_q, prv_d_q, pnd_d_q;
	logic [AW-1:0]     best_s_q, prv_s_q;
	logic [ID_W-1:0]   best_id_q, pnd_id_q;
	logic              best_f_q, prv_f_q, pnd_f_q;
	logic [K_W-1:0]    fnd_q, lim_q;
	logic              lim_f_q, rad_f_q;

	logic issue, hit, scan_end, dm_done, cand_ok, lim_hit;
	logic srch_more, shift_more, ins_ok, del_done;

	assign issue      = (iss_q < cnt_q);
	assign hit        = v_s1 && (id_rd_q == cmd_q.id);
	assign scan_end   = (iss_q == cnt_q) && !v_s1;
	assign dm_done    = (dim_q == DIM_N) && !dv_s1 && !dv_s2;
	assign srch_more  = (CNTW'(slot_s1) + 1'b1) < cnt_q;
	assign shift_more = (CNTW'(idx_q) + 2'd2) < cnt_q;
	assign lim_hit    = lim_f_q && ((fnd_q + 1'b1) == lim_q);
	assign dsat       = (acc_q > ACW'(DIST_MAX)) ? DIST_MAX : acc_q[DIST_W-1:0];

	// next candidate: above the previous result in (distance, slot) order, below the best so far
	assign cand_ok = v_s1
		&& (!rad_f_q || (dist_rd_q < cmd_q.radius))
		&& (!prv_f_q || (dist_rd_q > prv_d_q) || ((dist_rd_q == prv_d_q) && (slot_s1 > prv_s_q)))
		&& (!best_f_q || (dist_rd_q < best_d_q));

	assign ins_ok = (state_q == S_IDLE) && !cmd_empty && (cmd_data.op == OP_INSERT)
		&& (cnt_q != CAP_N);
	assign del_done = ((state_q == S_SRCH) && hit && (cmd_q.op == OP_DELETE) && !srch_more)
		|| ((state_q == S_SHIFT_WR) && !shift_more);

	assign res_data = reply_q;

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		case (state_q)
			S_SHIFT_RD: rd_addr = idx_q + 1'b1;
			S_DRD:      rd_addr = idx_q;
			default:    rd_addr = iss_q[AW-1:0];
		endcase
		case (state_q)
			S_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					case (cmd_data.op)
						OP_INSERT:           state_d = S_REPLY;
						OP_DELETE, OP_FIND:  state_d = (cnt_q == '0) ? S_REPLY : S_SRCH;
						OP_NEAREST, OP_RADIUS: state_d = (cnt_q == '0) ? S_REPLY : S_DRD;
						OP_KNN: state_d = (cnt_q == '0 || cmd_data.k == '0) ? S_REPLY : S_DRD;
						default:             state_d = S_IDLE;
					endcase
				end
			end
			S_SRCH: begin
				if (hit)
					state_d = (cmd_q.op == OP_DELETE && srch_more) ? S_SHIFT_RD : S_REPLY;
				else if (scan_end)
					state_d = S_REPLY;
			end
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: state_d = shift_more ? S_SHIFT_RD : S_REPLY;
			S_DRD:      state_d = S_DLD;
			S_DLD:      state_d = S_DMUL;
			S_DMUL: begin
				if (dm_done)
					state_d = ((CNTW'(idx_q) + 1'b1) == cnt_q) ? S_SEL : S_DRD;
			end
			S_SEL: begin
				if (scan_end) begin
					if (best_f_q) begin
						if (pnd_f_q)
							state_d = S_REPLY;
						else
							state_d = lim_hit ? S_FINAL : S_SEL;
					end else begin
						state_d = pnd_f_q ? S_FINAL : S_REPLY;
					end
				end
			end
			S_FINAL: state_d = S_REPLY;
			S_REPLY: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = ret_q;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ins_ok)
				cnt_q <= cnt_q + 1'b1;
			else if (del_done)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// store ports: one write address, one read address with registered read data
	always_ff @(posedge clk) begin
		id_rd_q   <= ids_mem[rd_addr];
		crd_rd_q  <= crd_mem[rd_addr];
		dist_rd_q <= dist_mem[rd_addr];
		if (ins_ok) begin
			ids_mem[cnt_q[AW-1:0]] <= cmd_data.id;
			crd_mem[cnt_q[AW-1:0]] <= pack_crd(cmd_data.coords);
		end else if (state_q == S_SHIFT_WR) begin
			ids_mem[idx_q] <= id_rd_q;
			crd_mem[idx_q] <= crd_rd_q;
		end
		if (state_q == S_DMUL && dm_done)
			dist_mem[idx_q] <= dsat;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (!cmd_empty) begin
					cmd_q    <= cmd_data;
					iss_q    <= '0;
					v_s1     <= 1'b0;
					idx_q    <= '0;
					ret_q    <= S_IDLE;
					fnd_q    <= '0;
					pnd_f_q  <= 1'b0;
					prv_f_q  <= 1'b0;
					best_f_q <= 1'b0;
					rad_f_q  <= (cmd_data.op == OP_RADIUS);
					lim_f_q  <= (cmd_data.op != OP_RADIUS);
					lim_q    <= (cmd_data.op == OP_NEAREST) ? K_W'(1) : cmd_data.k;
					reply_q.id      <= '0;
					reply_q.dist_sq <= '0;
					reply_q.present <= 1'b0;
					reply_q.last    <= 1'b1;
					case (cmd_data.op)
						OP_INSERT:  reply_q.status <= (cnt_q == CAP_N) ? STS_FULL : STS_OK;
						OP_NEAREST: reply_q.status <= STS_EMPTY;
						default:    reply_q.status <= STS_NOMATCH;
					endcase
				end
			end
			S_SRCH: begin
				if (issue)
					iss_q <= iss_q + 1'b1;
				v_s1    <= issue;
				slot_s1 <= iss_q[AW-1:0];
				if (hit) begin
					idx_q           <= slot_s1;
					reply_q.status  <= STS_OK;
					reply_q.present <= 1'b1;
				end
			end
			S_SHIFT_WR: idx_q <= idx_q + 1'b1;
			S_DLD: begin
				crd_sh_q <= crd_rd_q;
				qry_sh_q <= pack_crd(cmd_q.coords);
				dim_q    <= '0;
				dv_s1    <= 1'b0;
				dv_s2    <= 1'b0;
				acc_q    <= '0;
			end
			S_DMUL: begin
				// one coordinate a step: difference, square, accumulate
				if (dim_q != DIM_N) begin
					diff_s1  <= $signed({crd_sh_q[SB-1], crd_sh_q[SB-1:0]})
						- $signed({qry_sh_q[SB-1], qry_sh_q[SB-1:0]});
					crd_sh_q <= crd_sh_q >> SB;
					qry_sh_q <= qry_sh_q >> SB;
					dim_q    <= dim_q + 1'b1;
					dv_s1    <= 1'b1;
				end else begin
					dv_s1 <= 1'b0;
				end
				sq_s2 <= diff_s1 * diff_s1;
				dv_s2 <= dv_s1;
				if (dv_s2)
					acc_q <= acc_q + ACW'(unsigned'(sq_s2));
				if (dm_done)
					idx_q <= idx_q + 1'b1;
			end
			S_SEL: begin
				if (issue)
					iss_q <= iss_q + 1'b1;
				v_s1    <= issue;
				slot_s1 <= iss_q[AW-1:0];
				if (cand_ok) begin
					best_d_q  <= dist_rd_q;
					best_s_q  <= slot_s1;
					best_id_q <= id_rd_q;
					best_f_q  <= 1'b1;
				end
				if (scan_end) begin
					iss_q    <= '0;
					best_f_q <= 1'b0;
					if (best_f_q) begin
						prv_d_q  <= best_d_q;
						prv_s_q  <= best_s_q;
						prv_f_q  <= 1'b1;
						fnd_q    <= fnd_q + 1'b1;
						pnd_d_q  <= best_d_q;
						pnd_id_q <= best_id_q;
						pnd_f_q  <= 1'b1;
						if (pnd_f_q) begin
							reply_q <= '{status: STS_OK, id: pnd_id_q, dist_sq: pnd_d_q,
								present: 1'b0, last: 1'b0};
							ret_q   <= lim_hit ? S_FINAL : S_SEL;
						end
					end else if (!pnd_f_q) begin
						reply_q <= '{status: STS_NOMATCH, id: '0, dist_sq: '0,
							present: 1'b0, last: 1'b1};
						ret_q   <= S_IDLE;
					end
				end
			end
			S_FINAL: begin
				reply_q <= '{status: STS_OK, id: pnd_id_q, dist_sq: pnd_d_q,
					present: 1'b0, last: 1'b1};
				ret_q   <= S_IDLE;
			end
			default: ;
		endcase
	end

endmodule

// File: hdl/brute_force_nearest_neighbor_table_top.sv
// ----------------------------------------------------------------------------
// brute_force_nearest_neighbor_table_top
// Ordered point table with find/delete and nearest, radius, k-nearest search.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake           | payload
//  items     | in        | push / full         | operation, point_id, coord_0..5,
//            |           |                     | radius_sq, count_k
//  results   | out       | pop / empty         | status, match_id, distance_sq,
//            |           |                     | present, last
//
//  Insert writes at the end of the table; find and delete scan one entry
//  a cycle, and delete moves each later entry up a slot (read, then write).
//  Queries run a distance pass, one coordinate at a time, through one
//  shared squarer, then one selection pass per result.
//  A 2-deep command queue and 4-deep result queue decouple both sides;
//  after reset the table is empty and ready at once.
// ----------------------------------------------------------------------------
module brute_force_nearest_neighbor_table_top import bfnn_pkg::*; #(
	parameter int CAPACITY    = 64,
	parameter int DIMENSIONS  = 6,
	parameter int COORD_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [OP_W-1:0]    operation,
	input  logic [ID_W-1:0]    point_id,
	input  logic signed [15:0] coord_0,
	input  logic signed [15:0] coord_1,
	input  logic signed [15:0] coord_2,
	input  logic signed [15:0] coord_3,
	input  logic signed [15:0] coord_4,
	input  logic signed [15:0] coord_5,
	input  logic [DIST_W-1:0]  radius_sq,
	input  logic [K_W-1:0]     count_k,
	output logic               empty,
	input  logic               pop,
	output logic [STS_W-1:0]   status,
	output logic [ID_W-1:0]    match_id,
	output logic [DIST_W-1:0]  distance_sq,
	output logic               present,
	output logic               last
);
	cmd_t cmd_in, cmd_out;
	res_t res_in, res_out;
	logic cmd_push, cmd_full, cmd_pop, cmd_empty;
	logic res_push, res_full;
	logic [$bits(cmd_t)-1:0] cmd_raw;
	logic [$bits(res_t)-1:0] res_raw;

	bfnn_front u_front (
		.clk, .arst_n, .push, .full,
		.operation, .point_id,
		.coord_0, .coord_1, .coord_2, .coord_3, .coord_4, .coord_5,
		.radius_sq, .count_k,
		.cmd_full, .cmd_push, .cmd(cmd_in)
	);

	bfnn_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
		.clk, .arst_n,
		.wr(cmd_push), .din(cmd_in), .full(cmd_full),
		.rd(cmd_pop), .dout(cmd_raw), .empty(cmd_empty)
	);

	assign cmd_out = cmd_t'(cmd_raw);

	bfnn_back #(
		.CAPACITY(CAPACITY), .DIMENSIONS(DIMENSIONS), .COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk, .arst_n,
		.cmd_empty, .cmd_data(cmd_out), .cmd_pop,
		.res_full, .res_push, .res_data(res_in)
	);

	bfnn_fifo #(.WIDTH($bits(res_t)), .DEPTH(4)) u_res_q (
		.clk, .arst_n,
		.wr(res_push), .din(res_in), .full(res_full),
		.rd(pop), .dout(res_raw), .empty(empty)
	);

	assign res_out     = res_t'(res_raw);
	assign status      = res_out.status;
	assign match_id    = res_out.id;
	assign distance_sq = res_out.dist_sq;
	assign present     = res_out.present;
	assign last        = res_out.last;

endmodule

// File: hdl/bfnn_chk.sv
// ----------------------------------------------------------------------------
// bfnn_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bfnn_chk import bfnn_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input logic [STS_W-1:0]  status,
	input logic [ID_W-1:0]   match_id,
	input logic [DIST_W-1:0] distance_sq,
	input logic              present,
	input logic              last
);

	// results that are not ok carry no point and report zeros
	a_nopoint_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != STS_OK |-> match_id == '0 && distance_sq == '0)
		else $error("non-ok result carries a point");

	// present only on a single-result find or delete
	a_present: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && present |-> status == STS_OK && last && distance_sq == '0)
		else $error("present on unexpected result");

	// a multi-result transaction comes out in ascending distance
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !last |=> empty || distance_sq >= $past(distance_sq))
		else $error("results out of distance order");

	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(match_id) && $stable(distance_sq)
			&& $stable(last))
		else $error("waiting result changed");

endmodule

bind brute_force_nearest_neighbor_table_top bfnn_chk u_bfnn_chk (.*);

// File: sim/tb_brute_force_nearest_neighbor_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_brute_force_nearest_neighbor_table_top
// Drives table updates and searches through the push/full side and compares
// every result, field by field, against a behavioral point table kept here.
// ----------------------------------------------------------------------------
module tb_brute_force_nearest_neighbor_table_top;
	import bfnn_pkg::*;

	localparam int CAP  = 64;
	localparam int DIMS = 6;
	localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [OP_W-1:0] operation = OP_INSERT;
	logic [ID_W-1:0] point_id = '0;
	logic signed [15:0] coord_0 = '0, coord_1 = '0, coord_2 = '0;
	logic signed [15:0] coord_3 = '0, coord_4 = '0, coord_5 = '0;
	logic [DIST_W-1:0] radius_sq = '0;
	logic [K_W-1:0] count_k = '0;
	logic empty;
	logic pop = 1'b0;
	logic [STS_W-1:0] status;
	logic [ID_W-1:0] match_id;
	logic [DIST_W-1:0] distance_sq;
	logic present;
	logic last;

	brute_force_nearest_neighbor_table_top i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.operation(operation), .point_id(point_id),
		.coord_0(coord_0), .coord_1(coord_1), .coord_2(coord_2),
		.coord_3(coord_3), .coord_4(coord_4), .coord_5(coord_5),
		.radius_sq(radius_sq), .count_k(count_k),
		.empty(empty), .pop(pop), .status(status), .match_id(match_id),
		.distance_sq(distance_sq), .present(present), .last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// behavioral table
	logic [ID_W-1:0] tbl_id[CAP];
	logic signed [15:0] tbl_crd[CAP][DIMS];
	int tbl_cnt = 0;
	int n_items = 0;
	int n_results = 0;
	int n_errors = 0;
	int hold_off = 0;
	bit rx_random = 1'b1;
	res_t pending_results[$];

	function automatic logic [DIST_W-1:0] sq_dist(int slot, logic signed [15:0] q[DIMS]);
		logic [63:0] acc;
		longint diff;
		acc = 0;
		for (int d = 0; d < DIMS; d++) begin
			diff = longint'(tbl_crd[slot][d]) - longint'(q[d]);
			acc += 64'(diff * diff);
		end
		return (acc > 64'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];
	endfunction

	function automatic int slot_of(logic [ID_W-1:0] id);
		for (int i = 0; i < tbl_cnt; i++)
			if (tbl_id[i] == id) return i;
		return -1;
	endfunction

	function automatic res_t mk(logic [STS_W-1:0] s, logic [ID_W-1:0] id,
			logic [DIST_W-1:0] dd, logic p, logic l);
		res_t r;
		r.status = s; r.id = id; r.dist_sq = dd; r.present = p; r.last = l;
		return r;
	endfunction

	function automatic void queue_result(res_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	// work out the results of one accepted item and update the table
	task automatic predict_table(cmd_t c);
		logic signed [15:0] q[DIMS];
		logic [DIST_W-1:0] dl[$];
		int sl[$];
		logic [DIST_W-1:0] dv;
		int j, n, s;
		for (int d = 0; d < DIMS; d++) q[d] = c.coords[d*16 +: 16];
		case (c.op)
			OP_INSERT: begin
				if (tbl_cnt >= CAP) queue_result(mk(STS_FULL, 0, 0, 0, 1));
				else begin
					tbl_id[tbl_cnt] = c.id;
					for (int d = 0; d < DIMS; d++) tbl_crd[tbl_cnt][d] = q[d];
					tbl_cnt++;
					queue_result(mk(STS_OK, 0, 0, 0, 1));
				end
			end
			OP_DELETE: begin
				s = slot_of(c.id);
				if (s < 0) queue_result(mk(STS_NOMATCH, 0, 0, 0, 1));
				else begin
					for (int i = s; i + 1 < tbl_cnt; i++) begin
						tbl_id[i] = tbl_id[i+1];
						for (int d = 0; d < DIMS; d++) tbl_crd[i][d] = tbl_crd[i+1][d];
					end
					tbl_cnt--;
					queue_result(mk(STS_OK, 0, 0, 1, 1));
				end
			end
			OP_FIND: begin
				if (slot_of(c.id) < 0) queue_result(mk(STS_NOMATCH, 0, 0, 0, 1));
				else queue_result(mk(STS_OK, 0, 0, 1, 1));
			end
			OP_NEAREST, OP_RADIUS, OP_KNN: begin
				// stable insertion sort by distance
				for (int i = 0; i < tbl_cnt; i++) begin
					dv = sq_dist(i, q);
					if (c.op == OP_RADIUS && !(dv < c.radius)) continue;
					j = dl.size();
					while (j > 0 && dl[j-1] > dv) j--;
					dl.insert(j, dv);
					sl.insert(j, i);
				end
				n = dl.size();
				if (c.op == OP_NEAREST) begin
					if (tbl_cnt == 0) queue_result(mk(STS_EMPTY, 0, 0, 0, 1));
					else queue_result(mk(STS_OK, tbl_id[sl[0]], dl[0], 0, 1));
				end else begin
					if (c.op == OP_KNN && int'(c.k) < n) n = int'(c.k);
					if (n == 0) queue_result(mk(STS_NOMATCH, 0, 0, 0, 1));
					for (int i = 0; i < n; i++)
						queue_result(mk(STS_OK, tbl_id[sl[i]], dl[i], 0, i + 1 == n));
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
		n_errors++;
	endtask

	// receiver: random pop gap per result, optional long hold-off
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				pop <= 1'b0;
				hold_off--;
			end else begin
				gap = rx_random ? $urandom_range(0, 10) : 0;
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				pop <= 1'b1;
				@(posedge clk);
				while (empty) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n && pop && !empty) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result transactions", 1, 0);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status) report_mismatch("status", status, e.status);
				if (match_id !== e.id) report_mismatch("match_id", match_id, e.id);
				if (distance_sq !== e.dist_sq)
					report_mismatch("distance_sq", distance_sq, e.dist_sq);
				if (present !== e.present) report_mismatch("present", present, e.present);
				if (last !== e.last) report_mismatch("last", last, e.last);
			end
		end
	end

	bit tx_random = 1'b1;

	// push stays high into the next item when it follows with no gap
	task automatic send_item(cmd_t c);
		int gap;
		gap = tx_random ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		operation <= c.op; point_id <= c.id;
		coord_0 <= c.coords[0 +: 16];  coord_1 <= c.coords[16 +: 16];
		coord_2 <= c.coords[32 +: 16]; coord_3 <= c.coords[48 +: 16];
		coord_4 <= c.coords[64 +: 16]; coord_5 <= c.coords[80 +: 16];
		radius_sq <= c.radius; count_k <= c.k;
		do @(posedge clk); while (full);
		predict_table(c);
		n_items++;
		@(negedge clk);
	endtask

	function automatic cmd_t rand_cmd(logic [OP_W-1:0] op, int span);
		cmd_t c;
		c.op = op;
		c.id = 16'($urandom_range(0, 15));
		for (int d = 0; d < DIMS; d++)
			c.coords[d*16 +: 16] = (span == 0) ? 16'($urandom) :
				16'($urandom_range(0, 2*span) - span);
		c.radius = 35'({$urandom, $urandom} % 64'(DIST_MAX));
		if (span != 0) c.radius = c.radius % (35'(span) * span * 8);
		c.k = 7'($urandom_range(0, 8));
		return c;
	endfunction

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic test_directed();
		cmd_t c;
		c = rand_cmd(OP_NEAREST, 4);
		send_item(c);                                // nearest on empty table
		c.op = OP_RADIUS; send_item(c);              // radius on empty table
		c.op = OP_KNN; c.k = 5; send_item(c);
		c.op = OP_DELETE; send_item(c);
		c.op = OP_FIND; send_item(c);
		c = rand_cmd(OP_INSERT, 0);
		c.id = 16'hFFFF; c.coords = {6{16'sh7FFF}}; send_item(c);
		c.id = 16'h0000; c.coords = {6{16'sh8000}}; send_item(c);
		c.id = 16'hFFFF; c.coords = '0; send_item(c);     // duplicate id
		c.op = OP_NEAREST; c.coords = {6{16'sh8000}}; send_item(c);
		c.op = OP_KNN; c.k = 0; send_item(c);
		c.k = 7'd64; send_item(c);
		c.op = OP_RADIUS; c.radius = DIST_MAX; send_item(c);
		c.radius = '0; send_item(c);
		c.op = OP_FIND; c.id = 16'hFFFF; send_item(c);
		c.op = OP_DELETE; send_item(c);               // removes first duplicate
		c.op = OP_UNDEF_LO; send_item(c);             // ignored codes
		c.op = OP_UNDEF_HI; send_item(c);
		c.op = OP_KNN; c.k = 7'h7F; send_item(c);
		wait_drained();
	endtask

	// fill to capacity with receiver held off, then overflow
	task automatic test_fill();
		cmd_t c;
		hold_off = 400;
		while (tbl_cnt < CAP) begin
			c = rand_cmd(OP_INSERT, 40);
			c.id = 16'($urandom);
			send_item(c);
		end
		c = rand_cmd(OP_INSERT, 40); send_item(c);
		c = rand_cmd(OP_KNN, 40); c.k = 7'd64; send_item(c);
		c.op = OP_RADIUS; c.radius = DIST_MAX; send_item(c);
		wait_drained();
		// empty most of the table by deleting randomly chosen ids
		while (tbl_cnt > 6) begin
			c.op = OP_DELETE; c.id = tbl_id[$urandom_range(0, tbl_cnt - 1)];
			send_item(c);
		end
		wait_drained();
	endtask

	task automatic test_random(int count);
		cmd_t c;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (i == count / 2) begin
				rx_random = 1'b0; tx_random = 1'b0;
			end else if (i == count / 2 + 10) begin
				rx_random = 1'b1; tx_random = 1'b1;
			end
			if (r < 25 && tbl_cnt < 14) c = rand_cmd(OP_INSERT, 60);
			else if (r < 35) c = rand_cmd(OP_DELETE, 60);
			else if (r < 45) c = rand_cmd(OP_FIND, 60);
			else if (r < 60) c = rand_cmd(OP_NEAREST, 60);
			else if (r < 78) c = rand_cmd(OP_RADIUS, 60);
			else if (r < 96) c = rand_cmd(OP_KNN, 60);
			else c = rand_cmd(3'($urandom_range(6, 7)), 0);
			if (r % 7 == 0) c.coords = {$urandom, $urandom, $urandom};
			send_item(c);
		end
		wait_drained();
	endtask

	initial begin
		#10000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_fill();
		test_random(30);
		$display("Covered %0d items, %0d results: empty/full table, ties, k and radius edges.",
			n_items, n_results);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
